FILE: rtl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, codes and helpers for the tick-stepped I2C pin sequencer.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam int DELAY_BITS = 8;
    localparam int DELAY_CAP  = (1 << DELAY_BITS) - 1;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_STOP_DELAY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_ACK_DELAY   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_DELAY        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_BIT_DELAY  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_BIT_DELAY   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT      = 3'd5;

    localparam logic [7:0]  DELAY_RESET   = 8'd2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_WRITE    = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;
    localparam logic [2:0] OP_WAIT_ACK = 3'd5;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [14:0] {
        PH_IDLE = 15'b000000000000001,
        PH_ST1  = 15'b000000000000010,
        PH_ST2  = 15'b000000000000100,
        PH_SP1  = 15'b000000000001000,
        PH_SP2  = 15'b000000000010000,
        PH_WA1  = 15'b000000000100000,
        PH_WA2  = 15'b000000001000000,
        PH_POLL = 15'b000000010000000,
        PH_WB1  = 15'b000000100000000,
        PH_WB2  = 15'b000001000000000,
        PH_WB3  = 15'b000010000000000,
        PH_RB1  = 15'b000100000000000,
        PH_RB2  = 15'b001000000000000,
        PH_AK1  = 15'b010000000000000,
        PH_AK2  = 15'b100000000000000
    } phase_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } out_item_t;

    function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [7:0] d);
        logic [15:0] ext;
        ext = {8'd0, d};
        if (ext > 16'(DELAY_CAP)) begin
            return DELAY_BITS'(DELAY_CAP);
        end
        return DELAY_BITS'(ext);
    endfunction

endpackage

FILE: rtl/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-stepped I2C master that sequences SCL and SDA for start, stop, byte
// write, byte read with acknowledge, and acknowledge polling with timeout.
// ----------------------------------------------------------------------------
// Every input transaction is one time tick, and the block takes one tick per
// clock unless stalled. The sequencer state and the result register are
// updated by a single level of logic at the clock edge that accepts the tick,
// so the result of a tick is offered on the next cycle and a new tick can be
// accepted in the same cycle as long as the result register is empty or being
// taken. Phase lengths, counted in ticks, come from the configuration
// registers, which should only be written while the block is idle.
module i2c_master_bit_engine_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [i2cmbe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  i2cmbe_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output i2cmbe_pkg::out_item_t               m_data
);

    logic [7:0]  start_stop_delay_reg;
    logic [7:0]  wait_ack_delay_reg;
    logic [7:0]  ack_delay_reg;
    logic [7:0]  write_bit_delay_reg;
    logic [7:0]  read_bit_delay_reg;
    logic [15:0] ack_timeout_reg;

    i2cmbe_pkg::phase_t                  phase_reg, phase_next;
    logic [3:0]                          bit_index_reg, bit_index_next;
    logic [7:0]                          shift_reg, shift_next;
    logic [i2cmbe_pkg::DELAY_BITS-1:0]   delay_left_reg, delay_left_next;
    logic [15:0]                         poll_count_reg, poll_count_next;
    logic                                scl_reg, scl_next;
    logic                                sda_reg, sda_next;
    logic                                sda_oe_reg, sda_oe_next;
    logic                                ack_choice_reg, ack_choice_next;
    logic                                fail_flag_reg, fail_flag_next;
    logic [7:0]                          rx_hold_reg, rx_hold_next;
    logic                                done_next;
    logic [3:0]                          bit_inc;
    logic [7:0]                          shift_in;

    logic                                m_valid_reg;
    i2cmbe_pkg::out_item_t               m_data_reg, m_data_next;
    logic                                accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign bit_inc  = bit_index_reg + 4'd1;
    assign shift_in = {shift_reg[6:0], s_data.sda_sample};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_stop_delay_reg <= i2cmbe_pkg::DELAY_RESET;
            wait_ack_delay_reg   <= i2cmbe_pkg::DELAY_RESET;
            ack_delay_reg        <= i2cmbe_pkg::DELAY_RESET;
            write_bit_delay_reg  <= i2cmbe_pkg::DELAY_RESET;
            read_bit_delay_reg   <= i2cmbe_pkg::DELAY_RESET;
            ack_timeout_reg      <= i2cmbe_pkg::TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                i2cmbe_pkg::CFG_START_STOP_DELAY: start_stop_delay_reg <= cfg_data[7:0];
                i2cmbe_pkg::CFG_WAIT_ACK_DELAY:   wait_ack_delay_reg   <= cfg_data[7:0];
                i2cmbe_pkg::CFG_ACK_DELAY:        ack_delay_reg        <= cfg_data[7:0];
                i2cmbe_pkg::CFG_WRITE_BIT_DELAY:  write_bit_delay_reg  <= cfg_data[7:0];
                i2cmbe_pkg::CFG_READ_BIT_DELAY:   read_bit_delay_reg   <= cfg_data[7:0];
                i2cmbe_pkg::CFG_ACK_TIMEOUT:      ack_timeout_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        delay_left_next = delay_left_reg;
        poll_count_next = poll_count_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_oe_next     = sda_oe_reg;
        ack_choice_next = ack_choice_reg;
        fail_flag_next  = fail_flag_reg;
        rx_hold_next    = rx_hold_reg;
        done_next       = 1'b0;

        if (phase_reg == i2cmbe_pkg::PH_IDLE) begin
            unique case (s_data.operation)
                i2cmbe_pkg::OP_START: begin
                    sda_oe_next     = 1'b1;
                    sda_next        = 1'b1;
                    scl_next        = 1'b1;
                    delay_left_next = i2cmbe_pkg::sat_delay(start_stop_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_ST1;
                end
                i2cmbe_pkg::OP_STOP: begin
                    sda_oe_next     = 1'b1;
                    scl_next        = 1'b0;
                    sda_next        = 1'b0;
                    delay_left_next = i2cmbe_pkg::sat_delay(start_stop_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_SP1;
                end
                i2cmbe_pkg::OP_WRITE: begin
                    sda_oe_next     = 1'b1;
                    scl_next        = 1'b0;
                    bit_index_next  = 4'd0;
                    sda_next        = s_data.tx_byte[7];
                    shift_next      = {s_data.tx_byte[6:0], 1'b0};
                    delay_left_next = i2cmbe_pkg::sat_delay(write_bit_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_WB1;
                end
                i2cmbe_pkg::OP_READ: begin
                    sda_oe_next     = 1'b0;
                    sda_next        = 1'b1;
                    shift_next      = 8'd0;
                    bit_index_next  = 4'd0;
                    ack_choice_next = s_data.send_ack;
                    scl_next        = 1'b0;
                    delay_left_next = i2cmbe_pkg::sat_delay(read_bit_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_RB1;
                end
                i2cmbe_pkg::OP_WAIT_ACK: begin
                    sda_oe_next     = 1'b0;
                    sda_next        = 1'b1;
                    fail_flag_next  = 1'b0;
                    delay_left_next = i2cmbe_pkg::sat_delay(wait_ack_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_WA1;
                end
                default: begin
                end
            endcase
        end else if (delay_left_reg != '0) begin
            delay_left_next = delay_left_reg - 1'b1;
        end else begin
            unique case (phase_reg)
                i2cmbe_pkg::PH_ST1: begin
                    sda_next        = 1'b0;
                    delay_left_next = i2cmbe_pkg::sat_delay(start_stop_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_ST2;
                end
                i2cmbe_pkg::PH_ST2: begin
                    scl_next   = 1'b0;
                    phase_next = i2cmbe_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                i2cmbe_pkg::PH_SP1: begin
                    scl_next        = 1'b1;
                    sda_next        = 1'b1;
                    delay_left_next = i2cmbe_pkg::sat_delay(start_stop_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_SP2;
                end
                i2cmbe_pkg::PH_SP2: begin
                    phase_next = i2cmbe_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                i2cmbe_pkg::PH_WA1: begin
                    scl_next        = 1'b1;
                    delay_left_next = i2cmbe_pkg::sat_delay(wait_ack_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_WA2;
                end
                i2cmbe_pkg::PH_WA2: begin
                    poll_count_next = 16'd0;
                    phase_next      = i2cmbe_pkg::PH_POLL;
                end
                i2cmbe_pkg::PH_POLL: begin
                    if (!s_data.sda_sample) begin
                        scl_next   = 1'b0;
                        phase_next = i2cmbe_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end else if ({1'b0, poll_count_reg} + 17'd1 > {1'b0, ack_timeout_reg}) begin
                        fail_flag_next  = 1'b1;
                        sda_oe_next     = 1'b1;
                        scl_next        = 1'b0;
                        sda_next        = 1'b0;
                        delay_left_next = i2cmbe_pkg::sat_delay(start_stop_delay_reg);
                        phase_next      = i2cmbe_pkg::PH_SP1;
                    end else begin
                        poll_count_next = poll_count_reg + 16'd1;
                    end
                end
                i2cmbe_pkg::PH_WB1: begin
                    scl_next        = 1'b1;
                    delay_left_next = i2cmbe_pkg::sat_delay(write_bit_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_WB2;
                end
                i2cmbe_pkg::PH_WB2: begin
                    scl_next        = 1'b0;
                    delay_left_next = i2cmbe_pkg::sat_delay(write_bit_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_WB3;
                end
                i2cmbe_pkg::PH_WB3: begin
                    bit_index_next = bit_inc;
                    if (bit_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
                        phase_next = i2cmbe_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        sda_next        = shift_reg[7];
                        shift_next      = {shift_reg[6:0], 1'b0};
                        delay_left_next = i2cmbe_pkg::sat_delay(write_bit_delay_reg);
                        phase_next      = i2cmbe_pkg::PH_WB1;
                    end
                end
                i2cmbe_pkg::PH_RB1: begin
                    scl_next        = 1'b1;
                    delay_left_next = i2cmbe_pkg::sat_delay(read_bit_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_RB2;
                end
                i2cmbe_pkg::PH_RB2: begin
                    shift_next     = shift_in;
                    bit_index_next = bit_inc;
                    scl_next       = 1'b0;
                    if (bit_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
                        rx_hold_next    = shift_in;
                        sda_oe_next     = 1'b1;
                        sda_next        = !ack_choice_reg;
                        delay_left_next = i2cmbe_pkg::sat_delay(ack_delay_reg);
                        phase_next      = i2cmbe_pkg::PH_AK1;
                    end else begin
                        delay_left_next = i2cmbe_pkg::sat_delay(read_bit_delay_reg);
                        phase_next      = i2cmbe_pkg::PH_RB1;
                    end
                end
                i2cmbe_pkg::PH_AK1: begin
                    scl_next        = 1'b1;
                    delay_left_next = i2cmbe_pkg::sat_delay(ack_delay_reg);
                    phase_next      = i2cmbe_pkg::PH_AK2;
                end
                i2cmbe_pkg::PH_AK2: begin
                    scl_next   = 1'b0;
                    phase_next = i2cmbe_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                default: begin
                    phase_next = i2cmbe_pkg::PH_IDLE;
                end
            endcase
        end

        m_data_next.scl_level  = scl_next;
        m_data_next.sda_level  = sda_oe_next ? sda_next : 1'b1;
        m_data_next.sda_enable = sda_oe_next;
        m_data_next.busy_res   = (phase_next != i2cmbe_pkg::PH_IDLE);
        m_data_next.done_res   = done_next;
        m_data_next.rx_byte    = rx_hold_next;
        m_data_next.ack_failed = fail_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= i2cmbe_pkg::PH_IDLE;
            bit_index_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            delay_left_reg <= '0;
            poll_count_reg <= 16'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            sda_oe_reg     <= 1'b0;
            ack_choice_reg <= 1'b0;
            fail_flag_reg  <= 1'b0;
            rx_hold_reg    <= 8'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= accept || (m_valid_reg && !m_ready);
            if (accept) begin
                phase_reg      <= phase_next;
                bit_index_reg  <= bit_index_next;
                shift_reg      <= shift_next;
                delay_left_reg <= delay_left_next;
                poll_count_reg <= poll_count_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                sda_oe_reg     <= sda_oe_next;
                ack_choice_reg <= ack_choice_next;
                fail_flag_reg  <= fail_flag_next;
                rx_hold_reg    <= rx_hold_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // A transaction that ends a sequence always leaves the sequencer idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.done_res |-> !m_data_reg.busy_res)
        else $error("done reported while still busy");

    // An acknowledge failure always hands over to the stop sequence.
    a_fail_starts_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fail_flag_reg) |-> phase_reg == i2cmbe_pkg::PH_SP1)
        else $error("ack failure without stop sequence");

    // The sequencer must not advance while its result is held back.
    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> $stable(phase_reg) && $stable(delay_left_reg))
        else $error("sequencer advanced during output stall");

    // A released SDA line reads as pulled high.
    a_released_sda_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.sda_enable |-> m_data_reg.sda_level)
        else $error("released SDA not shown high");

endmodule

FILE: test/i2c_master_bit_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives the tick stream of the pin sequencer through a valid/ready driver,
// predicts SCL/SDA levels and status for every tick from a cycle model kept
// in step with accepted transactions, and checks each result transaction.
// Directed commands at reset and zero timing and at the largest acknowledge
// timeout come first, followed by random bus transfers and loose commands
// under several random timings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit_tb;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [7:0]  start_stop;
        logic [7:0]  wait_ack;
        logic [7:0]  ack_gap;
        logic [7:0]  write_bit;
        logic [7:0]  read_bit;
        logic [15:0] timeout;
    } timing_t;

    typedef struct packed {
        i2cmbe_pkg::phase_t                phase;
        logic [3:0]                        bit_idx;
        logic [7:0]                        shifter;
        logic [i2cmbe_pkg::DELAY_BITS-1:0] hold;
        logic [15:0]                       polls;
        logic                              scl;
        logic                              sda;
        logic                              sda_oe;
        logic                              ack_sel;
        logic                              failed;
        logic                              done;
        logic [7:0]                        rx;
    } seq_state_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [i2cmbe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [i2cmbe_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    i2cmbe_pkg::in_item_t               s_data = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    i2cmbe_pkg::out_item_t              m_data;

    timing_t                 timing;
    seq_state_t              plan_state;
    seq_state_t              drive_state;
    i2cmbe_pkg::in_item_t    ticks_q[$];
    i2cmbe_pkg::out_item_t   pins_q[$];
    i2cmbe_pkg::out_item_t   want_pins;
    logic [7:0] read_pattern;
    int         polls_until_ack;
    int         commands_issued = 0;
    int         ticks_planned = 0;
    int         ticks_sent = 0;
    int         results_checked = 0;
    int         settings_applied = 1;
    int         error_count = 0;
    int         cycle_count = 0;
    int         tx_gap = 0;
    int         tx_calm = 0;
    int         rx_stall = 0;
    int         rx_calm = 0;

    i2c_master_bit_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [i2cmbe_pkg::DELAY_BITS-1:0] hold_ticks(input logic [7:0] d);
        if (int'(d) > i2cmbe_pkg::DELAY_CAP) begin
            return i2cmbe_pkg::DELAY_BITS'(i2cmbe_pkg::DELAY_CAP);
        end
        return i2cmbe_pkg::DELAY_BITS'(d);
    endfunction

    function automatic seq_state_t seq_reset();
        seq_state_t s;
        s = '0;
        s.phase = i2cmbe_pkg::PH_IDLE;
        s.scl = 1'b1;
        s.sda = 1'b1;
        return s;
    endfunction

    function automatic seq_state_t seq_stop(input seq_state_t s, input timing_t t);
        seq_state_t n;
        n = s;
        n.sda_oe = 1'b1;
        n.scl = 1'b0;
        n.sda = 1'b0;
        n.hold = hold_ticks(t.start_stop);
        n.phase = i2cmbe_pkg::PH_SP1;
        return n;
    endfunction

    function automatic seq_state_t seq_emit(input seq_state_t s, input timing_t t);
        seq_state_t n;
        n = s;
        n.sda = s.shifter[7];
        n.shifter = {s.shifter[6:0], 1'b0};
        n.hold = hold_ticks(t.write_bit);
        n.phase = i2cmbe_pkg::PH_WB1;
        return n;
    endfunction

    function automatic seq_state_t pin_step(input seq_state_t s, input timing_t t,
                                            input i2cmbe_pkg::in_item_t it);
        seq_state_t n;
        n = s;
        n.done = 1'b0;
        if (s.phase == i2cmbe_pkg::PH_IDLE) begin
            case (it.operation)
                i2cmbe_pkg::OP_START: begin
                    n.sda_oe = 1'b1;
                    n.sda = 1'b1;
                    n.scl = 1'b1;
                    n.hold = hold_ticks(t.start_stop);
                    n.phase = i2cmbe_pkg::PH_ST1;
                end
                i2cmbe_pkg::OP_STOP: n = seq_stop(n, t);
                i2cmbe_pkg::OP_WRITE: begin
                    n.sda_oe = 1'b1;
                    n.scl = 1'b0;
                    n.shifter = it.tx_byte;
                    n.bit_idx = '0;
                    n = seq_emit(n, t);
                end
                i2cmbe_pkg::OP_READ: begin
                    n.sda_oe = 1'b0;
                    n.sda = 1'b1;
                    n.shifter = '0;
                    n.bit_idx = '0;
                    n.ack_sel = it.send_ack;
                    n.scl = 1'b0;
                    n.hold = hold_ticks(t.read_bit);
                    n.phase = i2cmbe_pkg::PH_RB1;
                end
                i2cmbe_pkg::OP_WAIT_ACK: begin
                    n.sda_oe = 1'b0;
                    n.sda = 1'b1;
                    n.failed = 1'b0;
                    n.hold = hold_ticks(t.wait_ack);
                    n.phase = i2cmbe_pkg::PH_WA1;
                end
                default: ;
            endcase
        end else if (s.hold != '0) begin
            n.hold = s.hold - 1'b1;
        end else begin
            case (s.phase)
                i2cmbe_pkg::PH_ST1: begin
                    n.sda = 1'b0;
                    n.hold = hold_ticks(t.start_stop);
                    n.phase = i2cmbe_pkg::PH_ST2;
                end
                i2cmbe_pkg::PH_ST2: begin
                    n.scl = 1'b0;
                    n.phase = i2cmbe_pkg::PH_IDLE;
                    n.done = 1'b1;
                end
                i2cmbe_pkg::PH_SP1: begin
                    n.scl = 1'b1;
                    n.sda = 1'b1;
                    n.hold = hold_ticks(t.start_stop);
                    n.phase = i2cmbe_pkg::PH_SP2;
                end
                i2cmbe_pkg::PH_SP2: begin
                    n.phase = i2cmbe_pkg::PH_IDLE;
                    n.done = 1'b1;
                end
                i2cmbe_pkg::PH_WA1: begin
                    n.scl = 1'b1;
                    n.hold = hold_ticks(t.wait_ack);
                    n.phase = i2cmbe_pkg::PH_WA2;
                end
                i2cmbe_pkg::PH_WA2: begin
                    n.polls = '0;
                    n.phase = i2cmbe_pkg::PH_POLL;
                end
                i2cmbe_pkg::PH_POLL: begin
                    if (!it.sda_sample) begin
                        n.scl = 1'b0;
                        n.phase = i2cmbe_pkg::PH_IDLE;
                        n.done = 1'b1;
                    end else if ({1'b0, s.polls} + 17'd1 > {1'b0, t.timeout}) begin
                        n.failed = 1'b1;
                        n = seq_stop(n, t);
                    end else begin
                        n.polls = s.polls + 16'd1;
                    end
                end
                i2cmbe_pkg::PH_WB1: begin
                    n.scl = 1'b1;
                    n.hold = hold_ticks(t.write_bit);
                    n.phase = i2cmbe_pkg::PH_WB2;
                end
                i2cmbe_pkg::PH_WB2: begin
                    n.scl = 1'b0;
                    n.hold = hold_ticks(t.write_bit);
                    n.phase = i2cmbe_pkg::PH_WB3;
                end
                i2cmbe_pkg::PH_WB3: begin
                    n.bit_idx = s.bit_idx + 4'd1;
                    if (n.bit_idx >= i2cmbe_pkg::BITS_PER_BYTE) begin
                        n.phase = i2cmbe_pkg::PH_IDLE;
                        n.done = 1'b1;
                    end else begin
                        n = seq_emit(n, t);
                    end
                end
                i2cmbe_pkg::PH_RB1: begin
                    n.scl = 1'b1;
                    n.hold = hold_ticks(t.read_bit);
                    n.phase = i2cmbe_pkg::PH_RB2;
                end
                i2cmbe_pkg::PH_RB2: begin
                    n.shifter = {s.shifter[6:0], it.sda_sample};
                    n.bit_idx = s.bit_idx + 4'd1;
                    n.scl = 1'b0;
                    if (n.bit_idx >= i2cmbe_pkg::BITS_PER_BYTE) begin
                        n.rx = n.shifter;
                        n.sda_oe = 1'b1;
                        n.sda = !s.ack_sel;
                        n.hold = hold_ticks(t.ack_gap);
                        n.phase = i2cmbe_pkg::PH_AK1;
                    end else begin
                        n.hold = hold_ticks(t.read_bit);
                        n.phase = i2cmbe_pkg::PH_RB1;
                    end
                end
                i2cmbe_pkg::PH_AK1: begin
                    n.scl = 1'b1;
                    n.hold = hold_ticks(t.ack_gap);
                    n.phase = i2cmbe_pkg::PH_AK2;
                end
                i2cmbe_pkg::PH_AK2: begin
                    n.scl = 1'b0;
                    n.phase = i2cmbe_pkg::PH_IDLE;
                    n.done = 1'b1;
                end
                default: n.phase = i2cmbe_pkg::PH_IDLE;
            endcase
        end
        return n;
    endfunction

    function automatic i2cmbe_pkg::out_item_t pin_outputs(input seq_state_t s);
        i2cmbe_pkg::out_item_t o;
        o.scl_level = s.scl;
        o.sda_level = s.sda_oe ? s.sda : 1'b1;
        o.sda_enable = s.sda_oe;
        o.busy_res = (s.phase != i2cmbe_pkg::PH_IDLE);
        o.done_res = s.done;
        o.rx_byte = s.rx;
        o.ack_failed = s.failed;
        return o;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        if (r < 99) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic int random_polls();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(0, 3);
        end
        if (r < 90) begin
            return int'(timing.timeout) + 1;
        end
        return $urandom_range(0, int'(timing.timeout));
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic push_tick(input logic [2:0] op, input logic [7:0] txb, input logic ack);
        i2cmbe_pkg::in_item_t it;
        it.operation = op;
        it.tx_byte = txb;
        it.send_ack = ack;
        if (plan_state.phase == i2cmbe_pkg::PH_RB2) begin
            it.sda_sample = read_pattern[3'd7 - plan_state.bit_idx[2:0]];
        end else if (plan_state.phase == i2cmbe_pkg::PH_POLL) begin
            it.sda_sample = (int'(plan_state.polls) >= polls_until_ack) ? 1'b0 : 1'b1;
        end else begin
            it.sda_sample = 1'($urandom);
        end
        plan_state = pin_step(plan_state, timing, it);
        ticks_q.push_back(it);
        ticks_planned++;
    endtask

    task automatic run_command(input logic [2:0] op, input logic [7:0] txb, input logic ack);
        push_tick(op, txb, ack);
        if (plan_state.phase != i2cmbe_pkg::PH_IDLE) begin
            commands_issued++;
        end
        while (plan_state.phase != i2cmbe_pkg::PH_IDLE) begin
            push_tick(3'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_ack(input int polls);
        polls_until_ack = polls;
        run_command(i2cmbe_pkg::OP_WAIT_ACK, 8'($urandom), 1'($urandom));
    endtask

    task automatic read_byte(input logic [7:0] pattern, input logic ack);
        read_pattern = pattern;
        run_command(i2cmbe_pkg::OP_READ, 8'($urandom), ack);
    endtask

    task automatic random_transfer();
        logic [7:0] addr;
        int         nbytes;
        addr = 8'($urandom);
        nbytes = $urandom_range(1, 2);
        run_command(i2cmbe_pkg::OP_START, 8'($urandom), 1'($urandom));
        run_command(i2cmbe_pkg::OP_WRITE, addr, 1'($urandom));
        wait_ack(random_polls());
        for (int k = 0; k < nbytes; k++) begin
            if (addr[0]) begin
                read_byte(8'($urandom), k != nbytes - 1);
            end else begin
                run_command(i2cmbe_pkg::OP_WRITE, 8'($urandom), 1'($urandom));
                wait_ack(random_polls());
            end
            if ($urandom_range(0, 3) == 0) begin
                run_command(i2cmbe_pkg::OP_TICK, 8'($urandom), 1'($urandom));
            end
        end
        run_command(i2cmbe_pkg::OP_STOP, 8'($urandom), 1'($urandom));
    endtask

    task automatic random_loose_command();
        read_pattern = 8'($urandom);
        polls_until_ack = random_polls();
        run_command(3'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(input logic [i2cmbe_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [i2cmbe_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
    endtask

    task automatic apply_timing(input timing_t t);
        write_reg(i2cmbe_pkg::CFG_START_STOP_DELAY, {8'($urandom), t.start_stop});
        write_reg(i2cmbe_pkg::CFG_WAIT_ACK_DELAY, {8'($urandom), t.wait_ack});
        write_reg(i2cmbe_pkg::CFG_ACK_DELAY, {8'($urandom), t.ack_gap});
        write_reg(i2cmbe_pkg::CFG_WRITE_BIT_DELAY, {8'($urandom), t.write_bit});
        write_reg(i2cmbe_pkg::CFG_READ_BIT_DELAY, {8'($urandom), t.read_bit});
        write_reg(i2cmbe_pkg::CFG_ACK_TIMEOUT, t.timeout);
        @(posedge aclk);
        cfg_we <= 1'b0;
        timing = t;
        settings_applied++;
    endtask

    task automatic wait_quiet();
        int calm;
        calm = 0;
        while (calm < 4) begin
            @(posedge aclk);
            if (ticks_q.size() == 0 && !s_valid && pins_q.size() == 0 && !m_valid) begin
                calm++;
            end else begin
                calm = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drive_state = seq_reset();
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                drive_state = pin_step(drive_state, timing, s_data);
                pins_q.push_back(pin_outputs(drive_state));
                ticks_sent++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (ticks_q.size() != 0) begin
                    s_data <= ticks_q.pop_front();
                    s_valid <= 1'b1;
                    if (tx_calm > 0) begin
                        tx_calm--;
                    end else begin
                        tx_gap = gap_length();
                        if ($urandom_range(0, 199) == 0) begin
                            tx_calm = $urandom_range(50, 300);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (pins_q.size() == 0) begin
                    $display("%0t: result with none outstanding, expected nothing, actual %h",
                             $time, m_data);
                    error_count++;
                end else begin
                    want_pins = pins_q.pop_front();
                    check_field("scl_level", want_pins.scl_level, m_data.scl_level);
                    check_field("sda_level", want_pins.sda_level, m_data.sda_level);
                    check_field("sda_enable", want_pins.sda_enable, m_data.sda_enable);
                    check_field("busy_res", want_pins.busy_res, m_data.busy_res);
                    check_field("done_res", want_pins.done_res, m_data.done_res);
                    check_field("rx_byte", want_pins.rx_byte, m_data.rx_byte);
                    check_field("ack_failed", want_pins.ack_failed, m_data.ack_failed);
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm--;
                end else begin
                    rx_stall = gap_length();
                    if ($urandom_range(0, 199) == 0) begin
                        rx_calm = $urandom_range(50, 300);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        timing_t t;
        int      phase_goal;
        timing = '{i2cmbe_pkg::DELAY_RESET, i2cmbe_pkg::DELAY_RESET, i2cmbe_pkg::DELAY_RESET,
                   i2cmbe_pkg::DELAY_RESET, i2cmbe_pkg::DELAY_RESET,
                   i2cmbe_pkg::TIMEOUT_RESET};
        plan_state = seq_reset();
        read_pattern = '0;
        polls_until_ack = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset timing: spare opcodes at idle, extreme bytes and a read with ACK.
        run_command(i2cmbe_pkg::OP_TICK, 8'h00, 1'b0);
        run_command(OP_SPARE_A, 8'hFF, 1'b1);
        run_command(OP_SPARE_B, 8'h00, 1'b0);
        run_command(i2cmbe_pkg::OP_START, 8'hFF, 1'b1);
        run_command(i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b1);
        wait_ack(0);
        read_byte(8'h5A, 1'b1);
        run_command(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0);
        wait_quiet();

        // Zero timing: an acknowledge timeout whose flag survives until the
        // next poll, then reads with ACK and NACK.
        apply_timing('0);
        run_command(i2cmbe_pkg::OP_START, 8'h00, 1'b0);
        run_command(i2cmbe_pkg::OP_WRITE, 8'h96, 1'b1);
        wait_ack(1);
        wait_ack(0);
        read_byte(8'hC3, 1'b1);
        read_byte(8'h3C, 1'b0);
        run_command(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0);
        wait_quiet();

        apply_timing('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF});
        wait_ack(2);
        run_command(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0);
        wait_quiet();

        for (int p = 0; p < 4; p++) begin
            t.start_stop = 8'($urandom_range(0, 3));
            t.wait_ack = 8'($urandom_range(0, 3));
            t.ack_gap = 8'($urandom_range(0, 3));
            t.write_bit = 8'($urandom_range(0, 3));
            t.read_bit = 8'($urandom_range(0, 3));
            t.timeout = 16'($urandom_range(0, 10));
            apply_timing(t);
            phase_goal = ticks_planned + 60;
            while (ticks_planned < phase_goal) begin
                if ($urandom_range(0, 99) < 50) begin
                    random_transfer();
                end else begin
                    random_loose_command();
                end
            end
            wait_quiet();
        end

        $display("Covered %0d commands over %0d ticks under %0d timing settings,",
                 commands_issued, ticks_sent, settings_applied);
        $display("with %0d results checked against the predicted pin levels.",
                 results_checked);
        if (error_count == 0 && pins_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
